@@ src/amc_pkg.sv @@
// ---------------------------------------------------------------------------
// amc_pkg: archive magic classifier constants
// Signature table, archive type codes and widths shared by the classifier.
// ---------------------------------------------------------------------------
package amc_pkg;

    localparam int SIG_COUNT  = 14;
    localparam int SIG_MAXLEN = 9;
    localparam int POS_LIMIT  = 24;

    typedef logic [4:0]           pos_t;
    typedef logic [3:0]           arc_type_t;
    typedef logic [SIG_COUNT-1:0] sig_mask_t;

    // Archive type codes as reported on the result port
    localparam arc_type_t TYPE_NONE  = 4'd0;
    localparam arc_type_t TYPE_7Z    = 4'd1;
    localparam arc_type_t TYPE_ACE   = 4'd2;
    localparam arc_type_t TYPE_ARJ   = 4'd3;
    localparam arc_type_t TYPE_BZIP2 = 4'd4;
    localparam arc_type_t TYPE_GZIP  = 4'd5;
    localparam arc_type_t TYPE_LZIP  = 4'd6;
    localparam arc_type_t TYPE_LZOP  = 4'd7;
    localparam arc_type_t TYPE_RAR   = 4'd8;
    localparam arc_type_t TYPE_RZIP  = 4'd9;
    localparam arc_type_t TYPE_XZ    = 4'd10;
    localparam arc_type_t TYPE_ZOO   = 4'd11;
    localparam arc_type_t TYPE_ZIP   = 4'd12;
    localparam arc_type_t TYPE_LRZIP = 4'd13;

    // Signature placement, in priority order
    localparam logic [4:0] SIG_OFFSET [SIG_COUNT] = '{
        5'd0, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
        5'd0, 5'd0, 5'd0, 5'd20, 5'd0, 5'd0, 5'd0
    };

    localparam logic [3:0] SIG_LENGTH [SIG_COUNT] = '{
        4'd6, 4'd7, 4'd2, 4'd3, 4'd2, 4'd4, 4'd9,
        4'd4, 4'd4, 4'd6, 4'd4, 4'd4, 4'd8, 4'd4
    };

    localparam arc_type_t SIG_TYPE [SIG_COUNT] = '{
        TYPE_7Z, TYPE_ACE, TYPE_ARJ, TYPE_BZIP2, TYPE_GZIP, TYPE_LZIP, TYPE_LZOP,
        TYPE_RAR, TYPE_RZIP, TYPE_XZ, TYPE_ZOO, TYPE_ZIP, TYPE_ZIP, TYPE_LRZIP
    };

    // Signature bytes; unused tail entries are zero and never compared
    localparam logic [7:0] SIG_BYTES [SIG_COUNT][SIG_MAXLEN] = '{
        '{8'h37, 8'h7A, 8'hBC, 8'hAF, 8'h27, 8'h1C, 8'h00, 8'h00, 8'h00},
        '{8'h2A, 8'h2A, 8'h41, 8'h43, 8'h45, 8'h2A, 8'h2A, 8'h00, 8'h00},
        '{8'h60, 8'hEA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h5A, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4C, 8'h5A, 8'h49, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h4C, 8'h5A, 8'h4F, 8'h00, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
        '{8'h52, 8'h61, 8'h72, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h5A, 8'h49, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFD, 8'h37, 8'h7A, 8'h58, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hDC, 8'hA7, 8'hC4, 8'hFD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h30, 8'h30, 8'h50, 8'h4B, 8'h03, 8'h04, 8'h00},
        '{8'h4C, 8'h52, 8'h5A, 8'h49, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

endpackage

@@ src/archive_magic_classifier_unit.sv @@
// Header bytes enter one per cycle on the hdr channel, starting at file offset zero, and
// last_byte marks the end of the buffer. A byte is taken in every cycle unless a finished
// result is still waiting and the result side stalls. The archive type appears on the type
// channel in the cycle after the last byte is transferred, held in a single output register;
// no result is produced for other bytes. Bytes past offset 23 are taken but not compared.
// After each last byte the match state returns to its reset values for the next buffer.
// ---------------------------------------------------------------------------
// archive_magic_classifier_unit
// Streams file header bytes against fixed archive signatures and reports the type.
// ---------------------------------------------------------------------------
module archive_magic_classifier_unit
    import amc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // header byte channel
    input  logic       hdr_valid,
    output logic       hdr_stall,
    input  logic [7:0] header_byte,
    input  logic       last_byte,
    // result channel
    output logic       type_valid,
    input  logic       type_stall,
    output logic [3:0] archive_type
);

    pos_t      pos_reg,   pos_next;
    sig_mask_t flags_reg, flags_next;
    logic      type_valid_reg;
    arc_type_t archive_type_reg, result_next;
    logic      hdr_xfer;

    // Input side waits only while an untaken result blocks the output register
    assign hdr_stall = type_valid_reg && type_stall;
    assign hdr_xfer  = hdr_valid && !hdr_stall;

    // Per-signature byte compare and new position
    always_comb
    begin
        logic [5:0] sig_end;
        logic [4:0] rel;
        sig_end    = '0;
        rel        = '0;
        flags_next = flags_reg;
        pos_next   = pos_reg;
        if (pos_reg < pos_t'(POS_LIMIT))
        begin
            for (int i = 0; i < SIG_COUNT; i++)
            begin
                sig_end = {1'b0, SIG_OFFSET[i]} + {2'b00, SIG_LENGTH[i]};
                rel     = pos_reg - SIG_OFFSET[i];
                if ((pos_reg >= SIG_OFFSET[i]) && ({1'b0, pos_reg} < sig_end))
                begin
                    if (SIG_BYTES[i][rel[3:0]] != header_byte)
                        flags_next[i] = 1'b0;
                end
            end
            pos_next = pos_reg + 5'd1;
        end
    end

    // First complete, fully matching signature in table order wins
    always_comb
    begin
        logic [5:0] sig_end;
        sig_end     = '0;
        result_next = TYPE_NONE;
        for (int i = SIG_COUNT - 1; i >= 0; i--)
        begin
            sig_end = {1'b0, SIG_OFFSET[i]} + {2'b00, SIG_LENGTH[i]};
            if ((sig_end <= {1'b0, pos_next}) && flags_next[i])
                result_next = SIG_TYPE[i];
        end
    end

    // Match state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            flags_reg <= '1;
        end
        else if (hdr_xfer)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                flags_reg <= '1;
            end
            else
            begin
                pos_reg   <= pos_next;
                flags_reg <= flags_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            type_valid_reg <= 1'b0;
        else if (hdr_xfer && last_byte)
            type_valid_reg <= 1'b1;
        else if (!type_stall)
            type_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (hdr_xfer && last_byte)
            archive_type_reg <= result_next;
    end

    assign type_valid   = type_valid_reg;
    assign archive_type = archive_type_reg;

    // Checks
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_xfer && last_byte |=> type_valid_reg)
        else $error("no result after last byte");

    a_state_rearmed: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_xfer && last_byte |=> (pos_reg == '0) && (flags_reg == '1))
        else $error("match state not rearmed after last byte");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= pos_t'(POS_LIMIT))
        else $error("byte position beyond limit");

    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        type_valid_reg |-> archive_type_reg <= TYPE_LRZIP)
        else $error("archive type out of range");

endmodule

@@ dv/tb_archive_magic_classifier_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_archive_magic_classifier_unit: archive magic classifier testbench
// Streams header buffers, some built around archive signatures and some pure
// noise, into the classifier with random gaps and result-side stalls. A
// behavioral classifier predicts the archive type of each buffer, and every
// result transfer is checked in order against it.
// ---------------------------------------------------------------------------
module tb_archive_magic_classifier_unit;
    import amc_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int STIM_ITEMS   = 1000;
    localparam int IMG_BYTES    = 32;
    localparam int SCAN_LIMIT   = 24;

    // Signature slots, in priority order
    localparam int MG_NONE     = -1;
    localparam int MG_7Z       = 0;
    localparam int MG_ACE      = 1;
    localparam int MG_ARJ      = 2;
    localparam int MG_BZIP2    = 3;
    localparam int MG_GZIP     = 4;
    localparam int MG_LZIP     = 5;
    localparam int MG_LZOP     = 6;
    localparam int MG_RAR      = 7;
    localparam int MG_RZIP     = 8;
    localparam int MG_XZ       = 9;
    localparam int MG_ZOO      = 10;
    localparam int MG_ZIP      = 11;
    localparam int MG_ZIP_SPAN = 12;
    localparam int MG_LRZIP    = 13;
    localparam int MG_COUNT    = 14;

    localparam int MAGIC_OFFS [MG_COUNT] = '{0, 7, 0, 0, 0, 0, 0, 0, 0, 0, 20, 0, 0, 0};
    localparam int MAGIC_LEN  [MG_COUNT] = '{6, 7, 2, 3, 2, 4, 9, 4, 4, 6, 4, 4, 8, 4};

    localparam arc_type_t MAGIC_KIND [MG_COUNT] = '{
        TYPE_7Z, TYPE_ACE, TYPE_ARJ, TYPE_BZIP2, TYPE_GZIP, TYPE_LZIP, TYPE_LZOP,
        TYPE_RAR, TYPE_RZIP, TYPE_XZ, TYPE_ZOO, TYPE_ZIP, TYPE_ZIP, TYPE_LRZIP
    };

    // Pattern bytes, first byte in the top bits
    localparam logic [71:0] MAGIC_PAT [MG_COUNT] = '{
        72'h37_7A_BC_AF_27_1C_00_00_00,
        72'h2A_2A_41_43_45_2A_2A_00_00,
        72'h60_EA_00_00_00_00_00_00_00,
        72'h42_5A_68_00_00_00_00_00_00,
        72'h1F_8B_00_00_00_00_00_00_00,
        72'h4C_5A_49_50_00_00_00_00_00,
        72'h89_4C_5A_4F_00_0D_0A_1A_0A,
        72'h52_61_72_21_00_00_00_00_00,
        72'h52_5A_49_50_00_00_00_00_00,
        72'hFD_37_7A_58_5A_00_00_00_00,
        72'hDC_A7_C4_FD_00_00_00_00_00,
        72'h50_4B_03_04_00_00_00_00_00,
        72'h50_4B_30_30_50_4B_03_04_00,
        72'h4C_52_5A_49_00_00_00_00_00
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;   // wait for all results before this transfer
    } hdr_item_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       hdr_valid   = 1'b0;
    logic       hdr_stall;
    logic [7:0] header_byte = 8'h00;
    logic       last_byte   = 1'b0;
    logic       type_valid;
    logic       type_stall  = 1'b0;
    logic [3:0] archive_type;

    hdr_item_t   hdr_q [$];
    hdr_item_t   hdr_next;
    arc_type_t   type_due [$];
    arc_type_t   type_want;
    int unsigned hdr_total   = 0;
    int unsigned hdr_sent    = 0;
    int unsigned send_gap    = 0;
    int unsigned recv_gap    = 0;
    int unsigned recv_draw;
    bit          send_calm   = 1'b0;
    bit          recv_calm   = 1'b0;
    int unsigned mismatches  = 0;
    int unsigned quiet_cycles = 0;

    // Classifier state mirrored by the testbench
    logic [4:0]          scan_pos    = 5'd0;
    logic [MG_COUNT-1:0] still_match = '1;

    archive_magic_classifier_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .hdr_valid    (hdr_valid),
        .hdr_stall    (hdr_stall),
        .header_byte  (header_byte),
        .last_byte    (last_byte),
        .type_valid   (type_valid),
        .type_stall   (type_stall),
        .archive_type (archive_type)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] magic_byte(input int sig, input int idx);
        return MAGIC_PAT[sig][71-8*idx -: 8];
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // Advance the match state by one header byte; on the last byte queue the type
    task automatic classify_byte(input logic [7:0] data, input logic last);
        arc_type_t kind;
        if (scan_pos < SCAN_LIMIT)
        begin
            for (int k = 0; k < MG_COUNT; k++)
                if (scan_pos >= MAGIC_OFFS[k] && scan_pos < MAGIC_OFFS[k] + MAGIC_LEN[k]
                    && magic_byte(k, scan_pos - MAGIC_OFFS[k]) != data)
                    still_match[k] = 1'b0;
            scan_pos = scan_pos + 5'd1;
        end
        if (last)
        begin
            kind = TYPE_NONE;
            // walk backward so the earliest slot in the table wins
            for (int k = MG_COUNT - 1; k >= 0; k--)
                if (MAGIC_OFFS[k] + MAGIC_LEN[k] <= scan_pos && still_match[k])
                    kind = MAGIC_KIND[k];
            type_due.push_back(kind);
            scan_pos    = 5'd0;
            still_match = '1;
        end
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic last, input logic hold);
        hdr_item_t item;
        item.data = data;
        item.last = last;
        item.hold = hold;
        hdr_q.push_back(item);
        hdr_total++;
    endtask

    // Random buffer with up to two signatures stamped in; lead is stamped last
    task automatic queue_buffer(input int lead, input int extra, input int n_bytes,
                                input int bad_at, input bit hold);
        logic [7:0] img [IMG_BYTES];
        int sig;
        for (int k = 0; k < IMG_BYTES; k++)
            img[k] = 8'($urandom);
        for (int s = 0; s < 2; s++)
        begin
            sig = (s == 0) ? extra : lead;
            if (sig != MG_NONE)
                for (int k = 0; k < MAGIC_LEN[sig]; k++)
                    img[MAGIC_OFFS[sig] + k] = magic_byte(sig, k);
        end
        if (bad_at >= 0)
            img[bad_at] = img[bad_at] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < n_bytes; k++)
            queue_byte(img[k], k == n_bytes - 1, hold && k == 0);
    endtask

    // Header byte driver; predicts on every accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid   <= 1'b0;
            header_byte <= 8'h00;
            last_byte   <= 1'b0;
            send_gap    <= 0;
            hdr_sent    <= 0;
        end
        else
        begin
            if (hdr_valid && !hdr_stall)
            begin
                classify_byte(header_byte, last_byte);
                hdr_sent <= hdr_sent + 1;
            end
            if (!hdr_valid || !hdr_stall)
            begin
                if (send_gap != 0)
                begin
                    hdr_valid <= 1'b0;
                    send_gap  <= send_gap - 1;
                end
                else if (hdr_q.size() != 0 && !(hdr_q[0].hold && type_due.size() != 0))
                begin
                    hdr_next    = hdr_q.pop_front();
                    hdr_valid   <= 1'b1;
                    header_byte <= hdr_next.data;
                    last_byte   <= hdr_next.last;
                    send_gap    <= pick_gap(send_calm);
                    if ($urandom_range(0, 39) == 0)
                        send_calm <= !send_calm;
                end
                else
                begin
                    hdr_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_stall <= 1'b0;
            recv_gap   <= 0;
        end
        else if (type_valid && !type_stall)
        begin
            if (type_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result transfer, archive_type %0d at %0t",
                             archive_type, $time);
            end
            else
            begin
                type_want = type_due.pop_front();
                if (archive_type !== type_want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: archive_type expected %0d, got %0d at %0t",
                                 type_want, archive_type, $time);
                end
            end
            recv_draw = pick_gap(recv_calm);
            type_stall <= (recv_draw != 0);
            recv_gap   <= recv_draw;
            if ($urandom_range(0, 29) == 0)
                recv_calm <= !recv_calm;
        end
        else if (recv_gap != 0)
        begin
            recv_gap   <= recv_gap - 1;
            type_stall <= (recv_gap > 1);
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            // occasional stall that starts while no result is pending
            recv_draw = pick_gap(recv_calm);
            type_stall <= (recv_draw != 0);
            recv_gap   <= recv_draw;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hdr_valid && !hdr_stall) || (type_valid && !type_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int lead;
        int extra;
        int span;
        int n_bytes;
        int bad_at;

        // single-byte buffers at both byte extremes: no signature fits
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        // exact signatures, gzip after a full drain
        queue_buffer(MG_GZIP, MG_NONE, 2, -1, 1'b1);
        queue_buffer(MG_ARJ, MG_NONE, 2, -1, 1'b0);
        queue_buffer(MG_ZIP, MG_NONE, 4, -1, 1'b0);
        // bzip2 cut short of its third byte
        queue_buffer(MG_BZIP2, MG_NONE, 2, -1, 1'b0);
        // lzip with a broken third byte
        queue_buffer(MG_LZIP, MG_NONE, 4, 2, 1'b0);

        // random buffers, mostly around a signature
        while (hdr_total < STIM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_buffer(MG_NONE, MG_NONE, $urandom_range(1, 30), -1,
                             $urandom_range(0, 39) == 0);
            else
            begin
                lead  = $urandom_range(0, MG_COUNT - 1);
                extra = MG_NONE;
                // offset signatures can share the buffer with a leading one
                if ((lead == MG_ACE || lead == MG_ZOO) && $urandom_range(0, 1) == 1)
                begin
                    do
                        extra = $urandom_range(0, MG_COUNT - 1);
                    while (extra == MG_ACE || extra == MG_ZOO);
                end
                span = MAGIC_OFFS[lead] + MAGIC_LEN[lead];
                case ($urandom_range(0, 5))
                    0:       n_bytes = $urandom_range(1, span);
                    1:       n_bytes = $urandom_range(span, 30);
                    default: n_bytes = span;
                endcase
                bad_at = ($urandom_range(0, 3) == 0)
                       ? MAGIC_OFFS[lead] + $urandom_range(0, MAGIC_LEN[lead] - 1) : -1;
                queue_buffer(lead, extra, n_bytes, bad_at, $urandom_range(0, 39) == 0);
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (hdr_sent != hdr_total)
            @(posedge clk);
        while (type_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ archive_magic_classifier_unit.f @@
src/amc_pkg.sv
src/archive_magic_classifier_unit.sv
dv/tb_archive_magic_classifier_unit.sv
